// ----- rtl/vrc_pkg.sv -----
package vrc_pkg;

	// Default sizing of the vertex reuse cache
	localparam int VRC_CACHE_ENTRIES  = 12;
	localparam int VRC_VERTEX_ID_BITS = 16;
	localparam int VRC_SLOT_BITS      = 16;

	// Bit positions inside the input tuser word
	localparam int VRC_IN_NEW_TREE  = 0;
	localparam int VRC_IN_NEW_FRAME = 1;

	// Bit positions inside the output tuser word
	localparam int VRC_OUT_HIT  = 0;
	localparam int VRC_OUT_FULL = 1;

endpackage

// ----- rtl/vrc_cell.sv -----
module vrc_cell import vrc_pkg::*; #(
	parameter int VERTEX_ID_BITS = VRC_VERTEX_ID_BITS,
	parameter int SLOT_BITS      = VRC_SLOT_BITS
) (
	input  logic                      clk,
	input  logic                      push,
	input  logic                      entry_valid,
	input  logic [VERTEX_ID_BITS-1:0] lookup_id,
	input  logic [VERTEX_ID_BITS-1:0] tag_in,
	input  logic [SLOT_BITS-1:0]      slot_in,
	input  logic                      hit_in,
	input  logic [SLOT_BITS-1:0]      hit_slot_in,
	output logic [VERTEX_ID_BITS-1:0] tag_out,
	output logic [SLOT_BITS-1:0]      slot_out,
	output logic                      hit_out,
	output logic [SLOT_BITS-1:0]      hit_slot_out
);

	logic [VERTEX_ID_BITS-1:0] tag_q;
	logic [SLOT_BITS-1:0]      slot_q;
	logic                      match;

	// Shift the entry one place toward the older end on a push
	always_ff @(posedge clk) begin
		if (push) begin
			tag_q  <= tag_in;
			slot_q <= slot_in;
		end
	end

	// Compare against the lookup id; a newer match upstream wins
	assign match        = entry_valid && (tag_q == lookup_id);
	assign hit_out      = hit_in || match;
	assign hit_slot_out = hit_in ? hit_slot_in : slot_q;

	assign tag_out  = tag_q;
	assign slot_out = slot_q;

endmodule

// ----- rtl/vrc_slot_alloc.sv -----
module vrc_slot_alloc import vrc_pkg::*; #(
	parameter int SLOT_BITS = VRC_SLOT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic                 push,
	input  logic                 new_frame,
	output logic [SLOT_BITS-1:0] slot,
	output logic                 full
);

	// Largest slot handed out; the all-ones value is reserved
	localparam logic [SLOT_BITS-1:0] SlotLimit = {{(SLOT_BITS-1){1'b1}}, 1'b0};

	logic [SLOT_BITS-1:0] next_slot_q;
	logic [SLOT_BITS-1:0] base;

	// Restart the counter at zero ahead of the lookup on a new frame
	assign base = new_frame ? '0 : next_slot_q;
	assign full = (base >= SlotLimit);
	assign slot = full ? SlotLimit : base;

	// Advance on a push below saturation, otherwise hold the base value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_slot_q <= '0;
		end else if (take) begin
			if (push && !full) begin
				next_slot_q <= base + 1'b1;
			end else begin
				next_slot_q <= slot;
			end
		end
	end

endmodule

// ----- rtl/fifo_vertex_reuse_cache_core.sv -----
// Result: each accepted input word gives a result word, registered on m_tdata/m_tuser.
// Throughput: one word per cycle unless m_tready stalls the output; the compare
//   runs along the cells in the accept cycle, and a miss shifts the cache one cell.
// Reset (arst_n low): valid count and slot counter go to zero, output word is dropped.
// Stored ids and slots are not reset; only cells below the valid count take part.
module fifo_vertex_reuse_cache_core import vrc_pkg::*; #(
	parameter int CACHE_ENTRIES  = VRC_CACHE_ENTRIES,
	parameter int VERTEX_ID_BITS = VRC_VERTEX_ID_BITS,
	parameter int SLOT_BITS      = VRC_SLOT_BITS,
	localparam int IN_DATA_W     = ((VERTEX_ID_BITS + 7) / 8) * 8,
	localparam int OUT_DATA_W    = ((SLOT_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // vertex_id
	input  logic [1:0]            s_tuser,  // new_tree, new_frame
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // buffer_index
	output logic [1:0]            m_tuser   // hit, full_res
);

	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] Entries = CNT_W'(CACHE_ENTRIES);

	logic                      take;
	logic [VERTEX_ID_BITS-1:0] lookup_id;
	logic                      new_tree;
	logic                      new_frame;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_base;
	logic                      push;
	logic [SLOT_BITS-1:0]      new_slot;
	logic                      slot_full;
	logic                      out_valid_q;

	logic [VERTEX_ID_BITS-1:0] tag_chain [CACHE_ENTRIES+1];
	logic [SLOT_BITS-1:0]      slot_chain [CACHE_ENTRIES+1];
	logic                      hit_chain [CACHE_ENTRIES+1];
	logic [SLOT_BITS-1:0]      hslot_chain [CACHE_ENTRIES+1];

	// Accept while the output register is empty or being drained
	assign s_tready  = !out_valid_q || m_tready;
	assign take      = s_tvalid && s_tready;
	assign lookup_id = s_tdata[VERTEX_ID_BITS-1:0];
	assign new_tree  = s_tuser[VRC_IN_NEW_TREE];
	assign new_frame = s_tuser[VRC_IN_NEW_FRAME];

	// Empty the cache ahead of the lookup on a new tree
	assign count_base = new_tree ? '0 : count_q;

	// Head of the chain: newest entry enters cell zero
	assign tag_chain[0]   = lookup_id;
	assign slot_chain[0]  = new_slot;
	assign hit_chain[0]   = 1'b0;
	assign hslot_chain[0] = '0;

	for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
		vrc_cell #(
			.VERTEX_ID_BITS(VERTEX_ID_BITS),
			.SLOT_BITS     (SLOT_BITS)
		) u_cell (
			.clk         (clk),
			.push        (push),
			.entry_valid (CNT_W'(k) < count_base),
			.lookup_id   (lookup_id),
			.tag_in      (tag_chain[k]),
			.slot_in     (slot_chain[k]),
			.hit_in      (hit_chain[k]),
			.hit_slot_in (hslot_chain[k]),
			.tag_out     (tag_chain[k+1]),
			.slot_out    (slot_chain[k+1]),
			.hit_out     (hit_chain[k+1]),
			.hit_slot_out(hslot_chain[k+1])
		);
	end

	// Push the word into the cache on a miss
	assign push = take && !hit_chain[CACHE_ENTRIES];

	vrc_slot_alloc #(
		.SLOT_BITS(SLOT_BITS)
	) u_alloc (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.push     (push),
		.new_frame(new_frame),
		.slot     (new_slot),
		.full     (slot_full)
	);

	// Track the number of valid cells, saturating at the cache size and restarting on a new tree
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (take) begin
			if (push && (count_base < Entries)) begin
				count_q <= count_base + 1'b1;
			end else begin
				count_q <= count_base;
			end
		end
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, loaded with each accepted word
	always_ff @(posedge clk) begin
		if (take) begin
			if (hit_chain[CACHE_ENTRIES]) begin
				m_tdata              <= OUT_DATA_W'(hslot_chain[CACHE_ENTRIES]);
				m_tuser[VRC_OUT_HIT]  <= 1'b1;
				m_tuser[VRC_OUT_FULL] <= 1'b0;
			end else begin
				m_tdata              <= OUT_DATA_W'(new_slot);
				m_tuser[VRC_OUT_HIT]  <= 1'b0;
				m_tuser[VRC_OUT_FULL] <= slot_full;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ----- rtl/vrc_checker.sv -----
module vrc_checker import vrc_pkg::*; #(
	parameter int SLOT_BITS   = VRC_SLOT_BITS,
	parameter int IN_DATA_W   = 16,
	parameter int OUT_DATA_W  = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic [1:0]            s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [1:0]            m_tuser
);

	localparam logic [SLOT_BITS-1:0] SlotLimit = {{(SLOT_BITS-1){1'b1}}, 1'b0};

	// A stalled result word holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// A hit never reports a saturated counter
	a_hit_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[VRC_OUT_HIT] && m_tuser[VRC_OUT_FULL]))
		else $error("hit and full set together");

	// A saturated push hands out the limit slot
	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[VRC_OUT_FULL] |-> m_tdata[SLOT_BITS-1:0] == SlotLimit)
		else $error("full result without limit slot");

	// A word that empties the cache is always a miss
	a_new_tree_miss: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[VRC_IN_NEW_TREE]
		|=> m_tvalid && !m_tuser[VRC_OUT_HIT])
		else $error("hit right after cache clear");

	// Clearing both cache and counter gives slot zero
	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser[VRC_IN_NEW_TREE] && s_tuser[VRC_IN_NEW_FRAME]
		|=> m_tdata[SLOT_BITS-1:0] == '0 && !m_tuser[VRC_OUT_FULL])
		else $error("restart did not give slot zero");

endmodule

bind fifo_vertex_reuse_cache_core vrc_checker #(
	.SLOT_BITS (SLOT_BITS),
	.IN_DATA_W (IN_DATA_W),
	.OUT_DATA_W(OUT_DATA_W)
) u_vrc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
